// ===== hdl/binary_lifting_lca_engine_macros.svh =====
// Assertion helpers shared by the engine. Each helper expects clk and arst_n in scope.
`ifndef BINARY_LIFTING_LCA_ENGINE_MACROS_SVH
`define BINARY_LIFTING_LCA_ENGINE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BLLE_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BLLE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/blle_pkg.sv =====
`timescale 1ns / 1ps

package blle_pkg;

	// Fixed field widths of the command and result ports.
	localparam int CMD_W  = 3;
	localparam int NODE_W = 10;
	localparam int DIST_W = 11;
	localparam int ST_W   = 2;

	typedef logic [CMD_W-1:0] cmd_t;
	typedef logic [ST_W-1:0]  status_t;

	localparam cmd_t CMD_ADD  = 3'd0;
	localparam cmd_t CMD_LCA  = 3'd1;
	localparam cmd_t CMD_KTH  = 3'd2;
	localparam cmd_t CMD_DIST = 3'd3;
	localparam cmd_t CMD_PATH = 3'd4;

	localparam status_t ST_OK     = 2'd0;
	localparam status_t ST_ABSENT = 2'd1;
	localparam status_t ST_DUP    = 2'd2;
	localparam status_t ST_BEYOND = 2'd3;

	typedef struct packed {
		logic [NODE_W-1:0] node;
		logic [DIST_W-1:0] distance;
		status_t           status;
	} result_t;

	typedef enum logic [16:0] {
		S_CLEAR  = 17'b00000000000000001,
		S_IDLE   = 17'b00000000000000010,
		S_FETCH  = 17'b00000000000000100,
		S_DECIDE = 17'b00000000000001000,
		S_ADD_RD = 17'b00000000000010000,
		S_ADD_WR = 17'b00000000000100000,
		S_UP     = 17'b00000000001000000,
		S_UP_WB  = 17'b00000000010000000,
		S_EQ     = 17'b00000000100000000,
		S_DN     = 17'b00000001000000000,
		S_DN_WB  = 17'b00000010000000000,
		S_PAR    = 17'b00000100000000000,
		S_PAR_WB = 17'b00001000000000000,
		S_RES    = 17'b00010000000000000,
		S_KCHK   = 17'b00100000000000000,
		S_KL     = 17'b01000000000000000,
		S_KL_WB  = 17'b10000000000000000
	} state_t;

endpackage

// ===== hdl/blle_ram.sv =====
`timescale 1ns / 1ps

// Simple RAM with one write port and two registered read ports.
module blle_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr0,
	input  logic [$clog2(DEPTH)-1:0] raddr1,
	output logic [WIDTH-1:0]         rdata0,
	output logic [WIDTH-1:0]         rdata1
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata0 <= mem_q[raddr0];
		rdata1 <= mem_q[raddr1];
	end

endmodule

// ===== hdl/binary_lifting_lca_engine.sv =====
// Binary-lifting tree engine. After reset the engine holds busy high while it clears the depth
// store one entry per cycle; commands are taken once busy falls. A command transfer happens at a
// rising edge with start high and busy low, and busy then stays high until the result has been
// produced. Each command yields exactly one result, shown for one cycle with done high; the
// receiver cannot stall, so results must be taken as they appear. Timing is set by the ancestor
// table, whose read port serves one lifting level per step: an add walks up the parent's chain
// to fill levels one through LEVELS of the new row; a kth-ancestor query visits levels zero
// through LEVELS, with a write-back step for each set bit of steps; a common-ancestor query
// lifts the deeper node and, unless both nodes then meet, walks them up the levels together
// and reads the parent, and a kth-path-node query adds a kth-ancestor walk on top of that.
// Rejected and unknown commands finish in the decide state without a table walk.
`timescale 1ns / 1ps
`include "binary_lifting_lca_engine_macros.svh"

module binary_lifting_lca_engine #(
	parameter int NODES  = 1024,
	parameter int LEVELS = 10
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [blle_pkg::CMD_W-1:0]   command,
	input  logic [blle_pkg::NODE_W-1:0]  node_a,
	input  logic [blle_pkg::NODE_W-1:0]  node_b,
	input  logic [blle_pkg::DIST_W-1:0]  steps,
	output logic                         done,
	output logic [blle_pkg::NODE_W-1:0]  result_node,
	output logic [blle_pkg::DIST_W-1:0]  result_distance,
	output logic [blle_pkg::ST_W-1:0]    status
);

	// Address and arithmetic widths derived from the tree size and level count.
	localparam int NW     = blle_pkg::NODE_W;
	localparam int DW     = blle_pkg::DIST_W;
	localparam int AW     = $clog2(NODES);
	localparam int LW     = $clog2(LEVELS + 1);
	localparam int PW     = LEVELS + 1;
	localparam int CW     = ((PW > DW) ? PW : DW) + 1;
	localparam int TDEPTH = NODES * (2 ** LW);
	localparam int TAW    = $clog2(TDEPTH);

	blle_pkg::state_t  state_q;
	blle_pkg::cmd_t    cmd_q;
	blle_pkg::result_t res_q;
	logic              done_q;

	logic [AW-1:0] clr_q;
	logic [LW-1:0] lvl_q;
	logic [NW-1:0] a_q, b_q, x_q, y_q, l_q;
	logic [DW-1:0] k_q, kk_q, da_q, db_q, dx_q, dy_q, dl_q;
	logic          rz0_q, rz1_q;

	// Depth store ports.
	logic          dp_we;
	logic [AW-1:0] dp_waddr;
	logic [DW-1:0] dp_wdata;
	logic [DW-1:0] dp_rd0, dp_rd1;

	// Ancestor table ports.
	logic           an_we;
	logic [TAW-1:0] an_waddr;
	logic [NW-1:0]  an_wdata;
	logic [NW-1:0]  an_rd0, an_rd1;

	logic          a_ok, b_ok, add_ok, jump, last_lvl, path_near;
	logic [PW-1:0] pow;
	logic [NW-1:0] t0, t1;
	logic [DW-1:0] path_len;

	// A node id is usable as an address only when it is nonzero and below NODES.
	assign a_ok = (a_q != '0) && (32'(a_q) < 32'(NODES));
	assign b_ok = (b_q != '0) && (32'(b_q) < 32'(NODES));

	// An add needs a fresh node and either the virtual root parent or a present parent.
	// The parent depth is already forced to zero when the parent id is unusable.
	assign add_ok = a_ok && (da_q == '0) && !((b_q != '0) && (db_q == '0));

	// Row zero of the table is never written; reads of it always return zero.
	assign t0 = rz0_q ? '0 : an_rd0;
	assign t1 = rz1_q ? '0 : an_rd1;

	// The 2^i-th ancestor of x has depth dx - 2^i when that is positive and zero otherwise,
	// so the deep node is lifted at level i exactly when dx >= dy + 2^i.
	assign pow      = PW'(1) << lvl_q;
	assign jump     = CW'(dx_q) >= (CW'(dy_q) + CW'(pow));
	assign last_lvl = (lvl_q == LW'(LEVELS));

	// Path length and the test for whether the kth path node lies on the node_a side.
	assign path_len  = da_q + db_q - {dl_q[DW-2:0], 1'b0};
	assign path_near = ({1'b0, dl_q} + {1'b0, k_q}) <= {1'b0, da_q};

	always_comb begin
		dp_we    = (state_q == blle_pkg::S_CLEAR) ||
		           ((state_q == blle_pkg::S_DECIDE) && (cmd_q == blle_pkg::CMD_ADD) && add_ok);
		dp_waddr = (state_q == blle_pkg::S_CLEAR) ? clr_q : AW'(a_q);
		dp_wdata = (state_q == blle_pkg::S_CLEAR) ? '0 : (db_q + DW'(1));

		// Level zero of a new row is its parent; higher levels come from the parent chain.
		an_we    = ((state_q == blle_pkg::S_DECIDE) && (cmd_q == blle_pkg::CMD_ADD) && add_ok) ||
		           (state_q == blle_pkg::S_ADD_WR);
		an_waddr = TAW'({AW'(a_q),
		           (state_q == blle_pkg::S_DECIDE) ? LW'(0) : (lvl_q + LW'(1))});
		an_wdata = (state_q == blle_pkg::S_DECIDE) ? b_q : t0;
	end

	blle_ram #(
		.WIDTH (DW),
		.DEPTH (NODES)
	) u_depth (
		.clk    (clk),
		.we     (dp_we),
		.waddr  (dp_waddr),
		.wdata  (dp_wdata),
		.raddr0 (AW'(node_a)),
		.raddr1 (AW'(node_b)),
		.rdata0 (dp_rd0),
		.rdata1 (dp_rd1)
	);

	blle_ram #(
		.WIDTH (NW),
		.DEPTH (TDEPTH)
	) u_anc (
		.clk    (clk),
		.we     (an_we),
		.waddr  (an_waddr),
		.wdata  (an_wdata),
		.raddr0 (TAW'({AW'(x_q), lvl_q})),
		.raddr1 (TAW'({AW'(y_q), lvl_q})),
		.rdata0 (an_rd0),
		.rdata1 (an_rd1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= blle_pkg::S_CLEAR;
			done_q  <= 1'b0;
			res_q   <= '0;
			cmd_q   <= '0;
			clr_q   <= '0;
			lvl_q   <= '0;
			a_q     <= '0;
			b_q     <= '0;
			x_q     <= '0;
			y_q     <= '0;
			l_q     <= '0;
			k_q     <= '0;
			kk_q    <= '0;
			da_q    <= '0;
			db_q    <= '0;
			dx_q    <= '0;
			dy_q    <= '0;
			dl_q    <= '0;
			rz0_q   <= 1'b0;
			rz1_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			// Remember whether the row read this cycle is row zero.
			rz0_q  <= (x_q == '0);
			rz1_q  <= (y_q == '0);

			unique case (state_q)
				blle_pkg::S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(NODES - 1)) begin
						state_q <= blle_pkg::S_IDLE;
					end
				end

				blle_pkg::S_IDLE: begin
					// Depth reads of both nodes are issued straight from the ports.
					if (start) begin
						cmd_q   <= command;
						a_q     <= node_a;
						b_q     <= node_b;
						k_q     <= steps;
						state_q <= blle_pkg::S_FETCH;
					end
				end

				blle_pkg::S_FETCH: begin
					da_q    <= a_ok ? dp_rd0 : '0;
					db_q    <= b_ok ? dp_rd1 : '0;
					state_q <= blle_pkg::S_DECIDE;
				end

				blle_pkg::S_DECIDE: begin
					unique case (cmd_q) inside
						blle_pkg::CMD_ADD: begin
							if (!a_ok || (da_q != '0)) begin
								res_q   <= '{node: '0, distance: '0, status: blle_pkg::ST_DUP};
								done_q  <= 1'b1;
								state_q <= blle_pkg::S_IDLE;
							end else if (!add_ok) begin
								res_q   <= '{node: '0, distance: '0, status: blle_pkg::ST_ABSENT};
								done_q  <= 1'b1;
								state_q <= blle_pkg::S_IDLE;
							end else begin
								// Walk up the parent's chain to fill levels one and above.
								x_q     <= b_q;
								lvl_q   <= '0;
								state_q <= blle_pkg::S_ADD_RD;
							end
						end
						blle_pkg::CMD_KTH: begin
							if (da_q == '0) begin
								res_q   <= '{node: '0, distance: '0, status: blle_pkg::ST_ABSENT};
								done_q  <= 1'b1;
								state_q <= blle_pkg::S_IDLE;
							end else begin
								x_q     <= a_q;
								dx_q    <= da_q;
								kk_q    <= k_q;
								state_q <= blle_pkg::S_KCHK;
							end
						end
						blle_pkg::CMD_LCA, blle_pkg::CMD_DIST, blle_pkg::CMD_PATH: begin
							if ((da_q == '0) || (db_q == '0)) begin
								res_q   <= '{node: '0, distance: '0, status: blle_pkg::ST_ABSENT};
								done_q  <= 1'b1;
								state_q <= blle_pkg::S_IDLE;
							end else begin
								// x is the deeper node; on equal depth node_a stays in x.
								if (da_q < db_q) begin
									x_q  <= b_q;
									dx_q <= db_q;
									y_q  <= a_q;
									dy_q <= da_q;
								end else begin
									x_q  <= a_q;
									dx_q <= da_q;
									y_q  <= b_q;
									dy_q <= db_q;
								end
								lvl_q   <= LW'(LEVELS);
								state_q <= blle_pkg::S_UP;
							end
						end
						default: begin
							res_q   <= '0;
							done_q  <= 1'b1;
							state_q <= blle_pkg::S_IDLE;
						end
					endcase
				end

				blle_pkg::S_ADD_RD: begin
					state_q <= blle_pkg::S_ADD_WR;
				end

				blle_pkg::S_ADD_WR: begin
					// The entry read here is written to the next level of the new row.
					x_q <= t0;
					if (lvl_q == LW'(LEVELS - 1)) begin
						res_q   <= '{node: '0, distance: '0, status: blle_pkg::ST_OK};
						done_q  <= 1'b1;
						state_q <= blle_pkg::S_IDLE;
					end else begin
						lvl_q   <= lvl_q + LW'(1);
						state_q <= blle_pkg::S_ADD_RD;
					end
				end

				blle_pkg::S_UP: begin
					if (jump) begin
						state_q <= blle_pkg::S_UP_WB;
					end else if (lvl_q == '0) begin
						state_q <= blle_pkg::S_EQ;
					end else begin
						lvl_q <= lvl_q - LW'(1);
					end
				end

				blle_pkg::S_UP_WB: begin
					x_q  <= t0;
					dx_q <= dx_q - DW'(pow);
					if (lvl_q == '0) begin
						state_q <= blle_pkg::S_EQ;
					end else begin
						lvl_q   <= lvl_q - LW'(1);
						state_q <= blle_pkg::S_UP;
					end
				end

				blle_pkg::S_EQ: begin
					if (x_q == y_q) begin
						l_q     <= x_q;
						dl_q    <= dx_q;
						state_q <= blle_pkg::S_RES;
					end else begin
						lvl_q   <= LW'(LEVELS);
						state_q <= blle_pkg::S_DN;
					end
				end

				blle_pkg::S_DN: begin
					state_q <= blle_pkg::S_DN_WB;
				end

				blle_pkg::S_DN_WB: begin
					// Both nodes move up together while their ancestors still differ.
					if (t0 != t1) begin
						x_q  <= t0;
						y_q  <= t1;
						dx_q <= dx_q - DW'(pow);
					end
					if (lvl_q == '0) begin
						state_q <= blle_pkg::S_PAR;
					end else begin
						lvl_q   <= lvl_q - LW'(1);
						state_q <= blle_pkg::S_DN;
					end
				end

				blle_pkg::S_PAR: begin
					state_q <= blle_pkg::S_PAR_WB;
				end

				blle_pkg::S_PAR_WB: begin
					l_q     <= t0;
					dl_q    <= dx_q - DW'(1);
					state_q <= blle_pkg::S_RES;
				end

				blle_pkg::S_RES: begin
					unique case (cmd_q) inside
						blle_pkg::CMD_LCA: begin
							res_q   <= '{node: l_q, distance: '0, status: blle_pkg::ST_OK};
							done_q  <= 1'b1;
							state_q <= blle_pkg::S_IDLE;
						end
						blle_pkg::CMD_DIST: begin
							res_q   <= '{node: '0, distance: path_len, status: blle_pkg::ST_OK};
							done_q  <= 1'b1;
							state_q <= blle_pkg::S_IDLE;
						end
						blle_pkg::CMD_PATH: begin
							if (k_q > path_len) begin
								res_q   <= '{node: '0, distance: '0, status: blle_pkg::ST_BEYOND};
								done_q  <= 1'b1;
								state_q <= blle_pkg::S_IDLE;
							end else if (path_near) begin
								x_q     <= a_q;
								dx_q    <= da_q;
								kk_q    <= k_q;
								state_q <= blle_pkg::S_KCHK;
							end else begin
								// Counted back from node_b, the target lies path_len - k steps up.
								x_q     <= b_q;
								dx_q    <= db_q;
								kk_q    <= path_len - k_q;
								state_q <= blle_pkg::S_KCHK;
							end
						end
						default: begin
							res_q   <= '0;
							done_q  <= 1'b1;
							state_q <= blle_pkg::S_IDLE;
						end
					endcase
				end

				blle_pkg::S_KCHK: begin
					if (kk_q >= dx_q) begin
						res_q   <= '{node: '0, distance: '0, status: blle_pkg::ST_OK};
						done_q  <= 1'b1;
						state_q <= blle_pkg::S_IDLE;
					end else begin
						lvl_q   <= '0;
						state_q <= blle_pkg::S_KL;
					end
				end

				blle_pkg::S_KL: begin
					// The low bit of the shifted step count selects this level.
					if (kk_q[0]) begin
						state_q <= blle_pkg::S_KL_WB;
					end else if (last_lvl) begin
						res_q   <= '{node: x_q, distance: '0, status: blle_pkg::ST_OK};
						done_q  <= 1'b1;
						state_q <= blle_pkg::S_IDLE;
					end else begin
						lvl_q <= lvl_q + LW'(1);
						kk_q  <= kk_q >> 1;
					end
				end

				blle_pkg::S_KL_WB: begin
					x_q <= t0;
					if (last_lvl) begin
						res_q   <= '{node: t0, distance: '0, status: blle_pkg::ST_OK};
						done_q  <= 1'b1;
						state_q <= blle_pkg::S_IDLE;
					end else begin
						lvl_q   <= lvl_q + LW'(1);
						kk_q    <= kk_q >> 1;
						state_q <= blle_pkg::S_KL;
					end
				end

				default: begin
					state_q <= blle_pkg::S_IDLE;
				end
			endcase
		end
	end

	assign busy            = (state_q != blle_pkg::S_IDLE);
	assign done            = done_q;
	assign result_node     = res_q.node;
	assign result_distance = res_q.distance;
	assign status          = res_q.status;

	// A command transfer always makes the engine busy in the next cycle.
	`BLLE_ASSERT_NEXT(a_start_busy, start && !busy, busy, "engine not busy after command transfer")
	// Results never come back to back, since every command passes through the fetch and decide states.
	`BLLE_ASSERT_NEXT(a_done_pulse, done, !done, "done held for more than one cycle")
	// Only a kth path node query can report a step beyond the path.
	`BLLE_ASSERT_IMPL(a_beyond_path, done && (status == blle_pkg::ST_BEYOND),
		cmd_q == blle_pkg::CMD_PATH, "beyond-path status on another command")
	// Only a distance query reports a nonzero distance.
	`BLLE_ASSERT_IMPL(a_dist_only, done && (result_distance != '0),
		cmd_q == blle_pkg::CMD_DIST, "distance reported on another command")

endmodule
